[rtl/srsw_pkg.sv]
package srsw_pkg;

  localparam int SEQ_COUNT    = 8;
  localparam int PAYLOAD_BITS = 64;

  localparam int          CFG_W        = 3;
  localparam logic [2:0]  WINDOW_RESET = 3'd4;

  localparam logic [1:0] REQ_SEND    = 2'd0;
  localparam logic [1:0] REQ_ACK     = 2'd1;
  localparam logic [1:0] REQ_TIMEOUT = 2'd2;

endpackage

[rtl/srsw_if.sv]
interface srsw_req_if #(
  parameter int SEQ_W = 3,
  parameter int PAY_W = 64
);
  logic             valid;
  logic             ready;
  logic [1:0]       req_type;
  logic [PAY_W-1:0] payload_word;
  logic [SEQ_W-1:0] seq_number;
  logic             checksum_ok;

  modport src (output valid, req_type, payload_word, seq_number, checksum_ok,
               input ready);
  modport snk (input valid, req_type, payload_word, seq_number, checksum_ok,
               output ready);
endinterface

interface srsw_rsp_if #(
  parameter int SEQ_W = 3,
  parameter int PAY_W = 64
);
  logic             valid;
  logic             ready;
  logic             accepted;
  logic             send_packet;
  logic [SEQ_W-1:0] packet_seq;
  logic [PAY_W-1:0] packet_payload;
  logic             timer_start;
  logic             timer_stop;
  logic [SEQ_W-1:0] window_base;
  logic [SEQ_W-1:0] next_sequence;

  modport src (output valid, accepted, send_packet, packet_seq, packet_payload,
               timer_start, timer_stop, window_base, next_sequence,
               input ready);
  modport snk (input valid, accepted, send_packet, packet_seq, packet_payload,
               timer_start, timer_stop, window_base, next_sequence,
               output ready);
endinterface

[rtl/selective_repeat_sender_window_unit.sv]
// Channel  Dir  Transaction
// req      in   one request: send, ack or timeout (req_type, payload, seq, checksum flag)
// rsp      out  one result per request: event fields plus window base / next seq
// cfg      in   window_size write, taken whenever cfg_wr_en is high
//
// Each request steps through DNEXT, DSEQ and EXEC to DONE (send, ignored requests); a timeout
// adds RD (payload RAM read), and a good ack adds SLIDE, which slides the base over k slots.
// A single modular-distance unit is shared between the next-sequence and the
// request-sequence offsets, stepped by the control FSM; the slide walks one slot a cycle.
// rst is synchronous: window base, next sequence and acked bits clear, window size 4.
// A request is taken while a finished result still waits in the output register;
// the result stage holds until rsp.ready.
module selective_repeat_sender_window_unit #(
  parameter int SEQ_COUNT    = srsw_pkg::SEQ_COUNT,
  parameter int PAYLOAD_BITS = srsw_pkg::PAYLOAD_BITS,
  localparam int SEQ_W       = $clog2(SEQ_COUNT)
) (
  input  logic                       clk,
  input  logic                       rst,
  srsw_req_if.snk                    req,
  srsw_rsp_if.src                    rsp,
  input  logic                       cfg_wr_en,
  input  logic [srsw_pkg::CFG_W-1:0] cfg_wr_data
);

  localparam int CW = (SEQ_W > srsw_pkg::CFG_W) ? SEQ_W : srsw_pkg::CFG_W;

  typedef enum logic [2:0] {
    ST_IDLE, ST_DNEXT, ST_DSEQ, ST_EXEC, ST_RD, ST_SLIDE, ST_DONE
  } state_t;

  state_t                     state;
  logic [srsw_pkg::CFG_W-1:0] window_size;
  logic [SEQ_W-1:0]           base;
  logic [SEQ_W-1:0]           next_seq;
  logic [SEQ_COUNT-1:0]       acked;

  logic [1:0]              req_q;
  logic [PAYLOAD_BITS-1:0] pay_q;
  logic [SEQ_W-1:0]        seq_q;
  logic                    csum_q;
  logic [SEQ_W-1:0]        dn;
  logic [SEQ_W-1:0]        ds;

  logic                    p_acc, p_snd, p_tstart, p_tstop, p_rd;
  logic [SEQ_W-1:0]        p_pseq;
  logic [PAYLOAD_BITS-1:0] p_ppay;

  logic                    rsp_valid;
  logic                    o_acc, o_snd, o_tstart, o_tstop;
  logic [SEQ_W-1:0]        o_pseq, o_base, o_next;
  logic [PAYLOAD_BITS-1:0] o_ppay;

  // shared modular distance unit: (a - base) mod SEQ_COUNT
  logic [SEQ_W-1:0] dist_a;
  logic [SEQ_W:0]   dist_wrap;
  logic [SEQ_W-1:0] dist_out;

  assign dist_a    = (state == ST_DNEXT) ? next_seq : seq_q;
  assign dist_wrap = {1'b0, dist_a} + (SEQ_W+1)'(SEQ_COUNT) - {1'b0, base};
  assign dist_out  = (dist_a >= base) ? (dist_a - base) : dist_wrap[SEQ_W-1:0];

  function automatic logic [SEQ_W-1:0] seq_inc(input logic [SEQ_W-1:0] x);
    seq_inc = (x == SEQ_W'(SEQ_COUNT - 1)) ? '0 : x + 1'b1;
  endfunction

  logic [CW-1:0] effw;
  logic          room;
  logic          seq_ok;
  logic          outstanding;
  logic          out_free;
  logic          ram_we;
  logic [PAYLOAD_BITS-1:0] ram_rdata;

  always_comb begin
    effw = CW'(window_size);
    if (effw == '0) begin
      effw = CW'(1);
    end
    if (effw > CW'(SEQ_COUNT / 2)) begin
      effw = CW'(SEQ_COUNT / 2);
    end
  end

  assign room        = CW'(dn) < effw;
  assign seq_ok      = {1'b0, seq_q} < (SEQ_W+1)'(SEQ_COUNT);
  assign outstanding = seq_ok && (ds < dn);
  assign out_free    = !rsp_valid || rsp.ready;
  assign ram_we      = (state == ST_EXEC) && (req_q == srsw_pkg::REQ_SEND) && room;

  assign req.ready = (state == ST_IDLE);

  srsw_ram #(
    .WIDTH (PAYLOAD_BITS),
    .DEPTH (SEQ_COUNT)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (next_seq),
    .wdata (pay_q),
    .raddr (seq_q),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      window_size <= srsw_pkg::WINDOW_RESET;
      base        <= '0;
      next_seq    <= '0;
      acked       <= '0;
      rsp_valid   <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        window_size <= cfg_wr_data;
      end
      if (rsp_valid && rsp.ready && state != ST_DONE) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (req.valid) begin
            req_q  <= req.req_type;
            pay_q  <= req.payload_word;
            seq_q  <= req.seq_number;
            csum_q <= req.checksum_ok;
            state  <= ST_DNEXT;
          end
        end
        ST_DNEXT: begin
          dn    <= dist_out;
          state <= ST_DSEQ;
        end
        ST_DSEQ: begin
          ds    <= dist_out;
          state <= ST_EXEC;
        end
        ST_EXEC: begin
          p_acc    <= 1'b0;
          p_snd    <= 1'b0;
          p_tstart <= 1'b0;
          p_tstop  <= 1'b0;
          p_rd     <= 1'b0;
          p_pseq   <= '0;
          p_ppay   <= '0;
          state    <= ST_DONE;
          case (req_q)
            srsw_pkg::REQ_SEND: begin
              if (room) begin
                acked[next_seq] <= 1'b0;
                p_acc    <= 1'b1;
                p_snd    <= 1'b1;
                p_tstart <= 1'b1;
                p_pseq   <= next_seq;
                p_ppay   <= pay_q;
                next_seq <= seq_inc(next_seq);
              end
            end
            srsw_pkg::REQ_ACK: begin
              if (csum_q && outstanding) begin
                acked[seq_q] <= 1'b1;
                p_tstop <= 1'b1;
                p_pseq  <= seq_q;
                state   <= ST_SLIDE;
              end
            end
            srsw_pkg::REQ_TIMEOUT: begin
              if (outstanding && !acked[seq_q]) begin
                p_snd    <= 1'b1;
                p_tstart <= 1'b1;
                p_pseq   <= seq_q;
                p_rd     <= 1'b1;
                state    <= ST_RD;
              end
            end
            default: begin
            end
          endcase
        end
        ST_RD: begin
          state <= ST_DONE;
        end
        ST_SLIDE: begin
          if (acked[base]) begin
            acked[base] <= 1'b0;
            base        <= seq_inc(base);
          end else begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            rsp_valid <= 1'b1;
            o_acc     <= p_acc;
            o_snd     <= p_snd;
            o_tstart  <= p_tstart;
            o_tstop   <= p_tstop;
            o_pseq    <= p_pseq;
            o_ppay    <= p_rd ? ram_rdata : p_ppay;
            o_base    <= base;
            o_next    <= next_seq;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign rsp.valid          = rsp_valid;
  assign rsp.accepted       = o_acc;
  assign rsp.send_packet    = o_snd;
  assign rsp.packet_seq     = o_pseq;
  assign rsp.packet_payload = o_ppay;
  assign rsp.timer_start    = o_tstart;
  assign rsp.timer_stop     = o_tstop;
  assign rsp.window_base    = o_base;
  assign rsp.next_sequence  = o_next;

  logic [SEQ_W:0] fill;
  assign fill = (next_seq >= base) ? {1'b0, next_seq - base}
              : ({1'b0, next_seq} + (SEQ_W+1)'(SEQ_COUNT) - {1'b0, base});

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |-> fill <= (SEQ_W+1)'(SEQ_COUNT / 2))
    else $error("outstanding count exceeds half the sequence space");

  a_next_unacked: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |-> !acked[next_seq])
    else $error("acked mark set at next sequence slot");

  a_start_stop: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !(o_tstart && o_tstop))
    else $error("timer start and stop in one result");

  a_accept_send: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && o_acc |-> o_snd && o_tstart)
    else $error("accepted send without packet and timer start");

endmodule

[rtl/srsw_ram.sv]
module srsw_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 8,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[tb/selective_repeat_sender_window_unit_tb.sv]
module selective_repeat_sender_window_unit_tb;

  localparam int SEQ_COUNT = srsw_pkg::SEQ_COUNT;
  localparam int PAYLOAD_BITS = srsw_pkg::PAYLOAD_BITS;
  localparam int CFG_W = srsw_pkg::CFG_W;
  localparam int SEQ_W = $clog2(SEQ_COUNT);
  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int SETTLE = 24;
  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_CYCLES = 300;
  localparam int MAX_PRINTED = 100;

  typedef struct packed {
    logic [1:0]              kind;
    logic [PAYLOAD_BITS-1:0] payload;
    logic [SEQ_W-1:0]        seq;
    logic                    csum;
  } req_item_t;

  typedef struct packed {
    logic                    accepted;
    logic                    send_packet;
    logic [SEQ_W-1:0]        packet_seq;
    logic [PAYLOAD_BITS-1:0] packet_payload;
    logic                    timer_start;
    logic                    timer_stop;
    logic [SEQ_W-1:0]        window_base;
    logic [SEQ_W-1:0]        next_sequence;
  } rsp_item_t;

  logic clk;
  logic rst;
  logic cfg_wr_en;
  logic [CFG_W-1:0] cfg_wr_data;

  srsw_req_if #(.SEQ_W(SEQ_W), .PAY_W(PAYLOAD_BITS)) req_ch ();
  srsw_rsp_if #(.SEQ_W(SEQ_W), .PAY_W(PAYLOAD_BITS)) rsp_ch ();

  selective_repeat_sender_window_unit uut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  // sender window state as the testbench sees it
  logic [CFG_W-1:0]        win_cfg;
  logic [SEQ_W-1:0]        base_q;
  logic [SEQ_W-1:0]        next_q;
  logic                    acked_q [SEQ_COUNT];
  logic [PAYLOAD_BITS-1:0] store_q [SEQ_COUNT];

  rsp_item_t pending_results [$];
  rsp_item_t oldest;

  int  mismatches = 0;
  int  hold_len = 0;
  int  idle_cycles = 0;
  bit  calm = 0;

  initial clk = 0;
  always #1 clk = ~clk;

  function automatic logic [SEQ_W-1:0] offset_of(logic [SEQ_W-1:0] s);
    return s - base_q;
  endfunction

  function automatic rsp_item_t window_step(req_item_t r);
    rsp_item_t o;
    logic [CFG_W-1:0] eff;
    int k;
    o = '0;
    eff = win_cfg;
    if (eff == '0) eff = CFG_W'(1);
    if (eff > CFG_W'(SEQ_COUNT / 2)) eff = CFG_W'(SEQ_COUNT / 2);
    case (r.kind)
      srsw_pkg::REQ_SEND: begin
        if (offset_of(next_q) < eff) begin
          store_q[next_q] = r.payload;
          acked_q[next_q] = 1'b0;
          o.accepted = 1'b1;
          o.send_packet = 1'b1;
          o.packet_seq = next_q;
          o.packet_payload = r.payload;
          o.timer_start = 1'b1;
          next_q = next_q + 1'b1;
        end
      end
      srsw_pkg::REQ_ACK: begin
        if (r.csum && offset_of(r.seq) < offset_of(next_q)) begin
          o.timer_stop = 1'b1;
          o.packet_seq = r.seq;
          acked_q[r.seq] = 1'b1;
          for (k = 0; k < SEQ_COUNT && acked_q[base_q]; k++) begin
            acked_q[base_q] = 1'b0;
            base_q = base_q + 1'b1;
          end
        end
      end
      srsw_pkg::REQ_TIMEOUT: begin
        if (offset_of(r.seq) < offset_of(next_q) && !acked_q[r.seq]) begin
          o.send_packet = 1'b1;
          o.packet_seq = r.seq;
          o.packet_payload = store_q[r.seq];
          o.timer_start = 1'b1;
        end
      end
      default: ;
    endcase
    o.window_base = base_q;
    o.next_sequence = next_q;
    return o;
  endfunction

  // mostly sends plus acks/timeouts aimed at outstanding numbers; some noise
  function automatic req_item_t pick_request();
    req_item_t r;
    int roll;
    logic [SEQ_W-1:0] span;
    r.kind = 2'($urandom);
    r.payload = PAYLOAD_BITS'({$urandom, $urandom});
    r.seq = SEQ_W'($urandom);
    r.csum = 1'($urandom);
    span = offset_of(next_q);
    roll = $urandom_range(0, 99);
    if (roll < 38) begin
      r.kind = srsw_pkg::REQ_SEND;
      case ($urandom_range(0, 15))
        0: r.payload = '0;
        1: r.payload = '1;
        default: ;
      endcase
    end else if (roll < 90) begin
      r.kind = (roll < 68) ? srsw_pkg::REQ_ACK : srsw_pkg::REQ_TIMEOUT;
      r.csum = ($urandom_range(0, 9) != 0);
      if (span != 0 && $urandom_range(0, 6) != 0)
        r.seq = base_q + SEQ_W'($urandom_range(0, span - 1));
    end
    return r;
  endfunction

  function automatic int draw_gap();
    if (calm || $urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, 18);
  endfunction

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    mismatches++;
    if (mismatches <= MAX_PRINTED)
      $display("mismatch %s: got %0h want %0h", what, got, want);
  endtask

  task automatic check_field(string what, logic [63:0] got, logic [63:0] want);
    if (got !== want) report(what, got, want);
  endtask

  task automatic send_request(req_item_t r);
    int gap;
    rsp_item_t o;
    gap = draw_gap();
    if (gap > 0) begin
      @(negedge clk);
      req_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    req_ch.valid <= 1'b1;
    req_ch.req_type <= r.kind;
    req_ch.payload_word <= r.payload;
    req_ch.seq_number <= r.seq;
    req_ch.checksum_ok <= r.csum;
    forever begin
      @(posedge clk);
      if (req_ch.ready) break;
    end
    o = window_step(r);
    pending_results.push_back(o);
  endtask

  task automatic issue(logic [1:0] k, logic [63:0] p, logic [SEQ_W-1:0] s, logic c);
    req_item_t r;
    r.kind = k;
    r.payload = PAYLOAD_BITS'(p);
    r.seq = s;
    r.csum = c;
    send_request(r);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_window(logic [CFG_W-1:0] v);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    win_cfg = v;
  endtask

  task automatic run_random(int n);
    repeat (n) begin
      if ($urandom_range(0, 49) == 0) calm = ($urandom_range(0, 2) == 0);
      send_request(pick_request());
    end
    calm = 0;
  endtask

  task automatic test_reset_window();
    issue(srsw_pkg::REQ_SEND, 64'h0, 3'd0, 1'b0);
    issue(srsw_pkg::REQ_SEND, '1, 3'd7, 1'b1);
    issue(srsw_pkg::REQ_SEND, 64'hA5A5_A5A5_A5A5_A5A5, 3'd2, 1'b0);
    issue(srsw_pkg::REQ_SEND, 64'h5A5A_5A5A_5A5A_5A5A, 3'd5, 1'b1);
    issue(srsw_pkg::REQ_SEND, 64'h1234_5678_9ABC_DEF0, 3'd0, 1'b0);  // window full
    issue(srsw_pkg::REQ_TIMEOUT, 64'h0, 3'd0, 1'b0);
    issue(srsw_pkg::REQ_TIMEOUT, '1, 3'd5, 1'b1);                    // not outstanding
    issue(srsw_pkg::REQ_ACK, 64'h0, 3'd1, 1'b0);                     // bad checksum
    issue(srsw_pkg::REQ_ACK, 64'h0, 3'd2, 1'b1);                     // out of order
    issue(srsw_pkg::REQ_ACK, 64'h0, 3'd2, 1'b1);                     // repeated ack
    issue(srsw_pkg::REQ_TIMEOUT, 64'h0, 3'd2, 1'b1);                 // already acked
    issue(srsw_pkg::REQ_ACK, 64'h0, 3'd0, 1'b1);
    issue(srsw_pkg::REQ_ACK, 64'h0, 3'd1, 1'b1);                     // slides over 2
    issue(REQ_UNUSED, '1, 3'd7, 1'b1);
    issue(srsw_pkg::REQ_ACK, 64'h0, 3'd7, 1'b1);
    issue(srsw_pkg::REQ_ACK, 64'h0, 3'd3, 1'b1);
    issue(srsw_pkg::REQ_SEND, 64'h8000_0000_0000_0001, 3'd0, 1'b0);
  endtask

  task automatic test_window_shrink();
    wait_idle();
    write_window(3'd7);                                    // clamps to half space
    issue(srsw_pkg::REQ_SEND, 64'hFFFF_0000_FFFF_0000, 3'd0, 1'b0);
    issue(srsw_pkg::REQ_SEND, 64'h0000_FFFF_0000_FFFF, 3'd0, 1'b0);
    issue(srsw_pkg::REQ_SEND, 64'hDEAD_BEEF_CAFE_F00D, 3'd0, 1'b0);  // wraps next to 0
    issue(srsw_pkg::REQ_SEND, 64'h1, 3'd0, 1'b0);
    wait_idle();
    write_window(3'd1);
    issue(srsw_pkg::REQ_SEND, 64'h2, 3'd0, 1'b0);          // outside shrunk window
    wait_idle();
    write_window(3'd0);
    issue(srsw_pkg::REQ_SEND, 64'h3, 3'd0, 1'b0);
    issue(srsw_pkg::REQ_TIMEOUT, 64'h0, 3'd6, 1'b0);
    issue(srsw_pkg::REQ_ACK, 64'h0, 3'd4, 1'b1);
    issue(srsw_pkg::REQ_ACK, 64'h0, 3'd5, 1'b1);
    issue(srsw_pkg::REQ_ACK, 64'h0, 3'd6, 1'b1);
    issue(srsw_pkg::REQ_ACK, 64'h0, 3'd7, 1'b1);
    issue(srsw_pkg::REQ_SEND, 64'h4, 3'd0, 1'b0);
    issue(srsw_pkg::REQ_SEND, 64'h5, 3'd0, 1'b0);          // window of one is full
  endtask

  task automatic test_backpressure();
    wait_idle();
    write_window(3'd4);
    calm = 1;
    hold_len = HOLD_CYCLES;
    run_random(60);
  endtask

  task automatic test_pause_for_drain();
    run_random(20);
    wait_idle();
    run_random(20);
  endtask

  task automatic test_random_windows();
    logic [CFG_W-1:0] sizes [8];
    int i;
    sizes = '{3'd2, 3'd0, 3'd7, 3'd3, 3'd1, 3'd5, 3'd6, 3'd4};
    for (i = 0; i < 8; i++) begin
      wait_idle();
      write_window(sizes[i]);
      run_random(170);
    end
  endtask

  // result side: random stalls, one long hold-off on request
  initial begin
    int n;
    rsp_ch.ready = 1'b0;
    wait (!rst);
    forever begin
      n = (hold_len > 0) ? hold_len : draw_gap();
      hold_len = 0;
      if (n > 0) begin
        @(negedge clk);
        rsp_ch.ready <= 1'b0;
        repeat (n - 1) @(negedge clk);
      end
      @(negedge clk);
      rsp_ch.ready <= 1'b1;
      forever begin
        @(posedge clk);
        if (rsp_ch.valid) break;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_results.size() == 0) begin
        report("unexpected result", 64'h0, 64'h0);
      end else begin
        oldest = pending_results.pop_front();
        check_field("accepted", 64'(rsp_ch.accepted), 64'(oldest.accepted));
        check_field("send_packet", 64'(rsp_ch.send_packet), 64'(oldest.send_packet));
        check_field("packet_seq", 64'(rsp_ch.packet_seq), 64'(oldest.packet_seq));
        check_field("packet_payload", 64'(rsp_ch.packet_payload),
                    64'(oldest.packet_payload));
        check_field("timer_start", 64'(rsp_ch.timer_start), 64'(oldest.timer_start));
        check_field("timer_stop", 64'(rsp_ch.timer_stop), 64'(oldest.timer_stop));
        check_field("window_base", 64'(rsp_ch.window_base), 64'(oldest.window_base));
        check_field("next_sequence", 64'(rsp_ch.next_sequence),
                    64'(oldest.next_sequence));
      end
    end
  end

  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    int i;
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    req_ch.valid = 1'b0;
    req_ch.req_type = srsw_pkg::REQ_SEND;
    req_ch.payload_word = '0;
    req_ch.seq_number = '0;
    req_ch.checksum_ok = 1'b0;
    win_cfg = srsw_pkg::WINDOW_RESET;
    base_q = '0;
    next_q = '0;
    for (i = 0; i < SEQ_COUNT; i++) begin
      acked_q[i] = 1'b0;
      store_q[i] = '0;
    end
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_window();
    test_window_shrink();
    test_backpressure();
    test_pause_for_drain();
    test_random_windows();

    wait_idle();
    if (pending_results.size() != 0)
      report("results never arrived", 64'(pending_results.size()), 64'h0);
    if (mismatches == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

[sim.f]
rtl/srsw_pkg.sv
rtl/srsw_if.sv
rtl/srsw_ram.sv
rtl/selective_repeat_sender_window_unit.sv
tb/selective_repeat_sender_window_unit_tb.sv
